FILE: hdl/ftpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftpp_pkg;

    // Frame bytes
    localparam logic [7:0] SYNC_A     = 8'h55;
    localparam logic [7:0] SYNC_B     = 8'hAA;
    localparam logic [7:0] TARGET_CMD = 8'h01;

    // Target record: detected byte, x, y, width, height (big-endian)
    localparam int         TGT_BYTES      = 9;
    localparam logic [7:0] TARGET_MIN_LEN = 8'(TGT_BYTES);

    // Payload buffer depth, default for the top-level parameter
    localparam int BUF_BYTES_DEF = 32;

    // Configuration port
    localparam int          ADDR_W          = 3;
    localparam int          DATA_W          = 32;
    localparam logic [0:0]  REG_GAP_TIMEOUT = 1'b0;
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd10;

    typedef struct packed {
        logic               frame_done;
        logic [7:0]         frame_cmd;
        logic [7:0]         target_detected;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [15:0]        target_width;
        logic [15:0]        target_height;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/ftpp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ftpp_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ftpp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ftpp_pkg::DATA_W-1:0] pwdata,
    output logic      [ftpp_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [15:0]                 o_gap_timeout
);

    logic [15:0] r_gap_timeout;
    logic        wr_en;
    logic [0:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ftpp_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= ftpp_pkg::GAP_TIMEOUT_RST;
        end else if (wr_en && (reg_idx == ftpp_pkg::REG_GAP_TIMEOUT)) begin
            r_gap_timeout <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == ftpp_pkg::REG_GAP_TIMEOUT) begin
            prdata = {{(ftpp_pkg::DATA_W-16){1'b0}}, r_gap_timeout};
        end
    end

    assign o_gap_timeout = r_gap_timeout;

endmodule

`default_nettype wire

FILE: hdl/ftpp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ftpp_core #(
    parameter int BUF_BYTES = ftpp_pkg::BUF_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic [15:0]       i_gap_timeout,
    output ftpp_pkg::t_result      o_result
);

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;

    localparam logic [7:0] BUF_LIM = 8'(BUF_BYTES);
    localparam int         NB      = ftpp_pkg::TGT_BYTES;

    logic [2:0]         r_phase, n_phase;
    logic [7:0]         r_cmd, n_cmd;
    logic [7:0]         r_len, n_len;
    logic [7:0]         r_cnt, n_cnt;
    logic [7:0]         r_sum, n_sum;
    logic [31:0]        r_last_time;
    logic [7:0]         r_det, n_det;
    logic [15:0]        r_x, n_x;
    logic [15:0]        r_y, n_y;
    logic [15:0]        r_w, n_w;
    logic [15:0]        r_h, n_h;
    logic [7:0]         r_cap [NB];
    logic [NB-1:0]      cap_we;
    logic [31:0]        gap;
    logic [2:0]         ph;
    logic               done;

    // Drop the frame when the gap since the last byte is too long
    assign gap = i_now_ms - r_last_time;

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_det   = r_det;
        n_x     = r_x;
        n_y     = r_y;
        n_w     = r_w;
        n_h     = r_h;
        done    = 1'b0;
        cap_we  = '0;

        if ((r_phase != PH_HDR1) && (gap > {16'd0, i_gap_timeout})) begin
            ph = PH_HDR1;
        end else begin
            ph = r_phase;
        end

        case (ph)
            PH_HDR1: begin
                n_phase = PH_HDR1;
                if (i_rx_byte == ftpp_pkg::SYNC_A) begin
                    n_phase = PH_HDR2;
                    n_sum   = i_rx_byte;
                end
            end
            PH_HDR2: begin
                if (i_rx_byte == ftpp_pkg::SYNC_B) begin
                    n_phase = PH_CMD;
                    n_sum   = r_sum + i_rx_byte;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len = i_rx_byte;
                if (i_rx_byte > BUF_LIM) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_sum   = r_sum + i_rx_byte;
                    n_cnt   = 8'd0;
                    n_phase = (i_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                for (int k = 0; k < NB; k++) begin
                    cap_we[k] = (r_cnt == 8'(k));
                end
                n_cnt = r_cnt + 8'd1;
                n_sum = r_sum + i_rx_byte;
                if (n_cnt >= r_len) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (r_sum == i_rx_byte) begin
                    if ((r_cmd == ftpp_pkg::TARGET_CMD) &&
                        (r_len >= ftpp_pkg::TARGET_MIN_LEN)) begin
                        n_det = r_cap[0];
                        n_x   = {r_cap[1], r_cap[2]};
                        n_y   = {r_cap[3], r_cap[4]};
                        n_w   = {r_cap[5], r_cap[6]};
                        n_h   = {r_cap[7], r_cap[8]};
                    end
                    done = 1'b1;
                end
                n_phase = PH_HDR1;
            end
            default: begin
                n_phase = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR1;
            r_cmd       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_last_time <= '0;
            r_det       <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_w         <= '0;
            r_h         <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_last_time <= i_now_ms;
            r_det       <= n_det;
            r_x         <= n_x;
            r_y         <= n_y;
            r_w         <= n_w;
            r_h         <= n_h;
        end
    end

    // Only the first payload bytes are ever read back: keep those
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NB; k++) begin
            if (i_step && cap_we[k]) begin
                r_cap[k] <= i_rx_byte;
            end
        end
    end

    assign o_result.frame_done      = done;
    assign o_result.frame_cmd       = n_cmd;
    assign o_result.target_detected = n_det;
    assign o_result.target_x        = n_x;
    assign o_result.target_y        = n_y;
    assign o_result.target_width    = n_w;
    assign o_result.target_height   = n_h;

endmodule

`default_nettype wire

FILE: hdl/framed_target_packet_parser_unit.sv
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+------------------------------------
// byte in   | in        | i_in_valid / o_in_ready     | i_rx_byte, i_now_ms
// result    | out       | o_out_valid / i_out_ready   | o_frame_done, o_frame_cmd, o_target_*
// config    | in/out    | APB: psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One byte request per cycle sustained while the result side does not stall; a byte
// passes the input register, then the parse logic into the result register, and
// its result is held there until the consumer takes it.
// Reset is synchronous, active low; it returns the parser to the header hunt and
// clears the latched target and gap_timeout to 10 ms.
// A stalled result holds the result register; the input register then holds one
// more byte, and o_in_ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module framed_target_packet_parser_unit #(
    parameter int BUF_BYTES = ftpp_pkg::BUF_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // byte in
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic [31:0]                 i_now_ms,
    // result
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_frame_done,
    output logic      [7:0]                  o_frame_cmd,
    output logic      [7:0]                  o_target_detected,
    output logic signed [15:0]               o_target_x,
    output logic signed [15:0]               o_target_y,
    output logic      [15:0]                 o_target_width,
    output logic      [15:0]                 o_target_height,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ftpp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ftpp_pkg::DATA_W-1:0] pwdata,
    output logic      [ftpp_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    logic               r_in_valid;
    logic [7:0]         r_rx_byte;
    logic [31:0]        r_now_ms;
    logic               r_out_valid;
    ftpp_pkg::t_result  r_out;
    ftpp_pkg::t_result  core_result;
    logic [15:0]        gap_timeout;
    logic               advance;
    logic               in_take;

    // Move the held byte into the result register when that slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    ftpp_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_gap_timeout (gap_timeout)
    );

    ftpp_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_rx_byte     (r_rx_byte),
        .i_now_ms      (r_now_ms),
        .i_gap_timeout (gap_timeout),
        .o_result      (core_result)
    );

    // Input register: hold a byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rx_byte <= i_rx_byte;
            r_now_ms  <= i_now_ms;
        end
    end

    // Result register: hold until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_done      = r_out.frame_done;
    assign o_frame_cmd       = r_out.frame_cmd;
    assign o_target_detected = r_out.target_detected;
    assign o_target_x        = r_out.target_x;
    assign o_target_y        = r_out.target_y;
    assign o_target_width    = r_out.target_width;
    assign o_target_height   = r_out.target_height;

endmodule

`default_nettype wire

FILE: hdl/ftpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ftpp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_frame_done,
    input wire logic [7:0]  o_frame_cmd,
    input wire logic [7:0]  o_target_detected,
    input wire logic [15:0] o_target_x,
    input wire logic [15:0] o_target_y,
    input wire logic [15:0] o_target_width,
    input wire logic [15:0] o_target_height
);

    logic [71:0] tgt;

    assign tgt = {o_target_detected, o_target_x, o_target_y,
                  o_target_width, o_target_height};

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_frame_done) && $stable(o_frame_cmd) && $stable(tgt))
        else $error("result payload changed while stalled");

    // With an empty result slot the byte input is never stalled
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result slot");

    // The target only changes with a good target frame
    a_tgt_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && o_out_valid && (tgt != $past(tgt))
            |-> o_frame_done && (o_frame_cmd == ftpp_pkg::TARGET_CMD))
        else $error("target changed without a good target frame");

endmodule

bind framed_target_packet_parser_unit ftpp_checker u_ftpp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_frame_done      (o_frame_done),
    .o_frame_cmd       (o_frame_cmd),
    .o_target_detected (o_target_detected),
    .o_target_x        (o_target_x),
    .o_target_y        (o_target_y),
    .o_target_width    (o_target_width),
    .o_target_height   (o_target_height)
);

`default_nettype wire

FILE: dv/framed_target_packet_parser_unit_test.sv
`timescale 1ns / 1ps

module framed_target_packet_parser_unit_test;

    localparam int ADDR_W = ftpp_pkg::ADDR_W;
    localparam int DATA_W = ftpp_pkg::DATA_W;
    localparam logic [ADDR_W-1:0] GAP_TIMEOUT_ADDR =
        ADDR_W'(4 * int'(ftpp_pkg::REG_GAP_TIMEOUT));

    // Parser phases as seen from the byte stream
    typedef enum logic [2:0] {
        HUNT_SYNC_A,
        HUNT_SYNC_B,
        TAKE_CMD,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } t_parse_phase;

    // Ways a generated frame can go wrong on the link
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_LATE_BYTE,
        FRAME_TRUNCATED
    } t_frame_fault;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte;
    logic [31:0]        i_now_ms;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_frame_done;
    logic [7:0]         o_frame_cmd;
    logic [7:0]         o_target_detected;
    logic signed [15:0] o_target_x;
    logic signed [15:0] o_target_y;
    logic [15:0]        o_target_width;
    logic [15:0]        o_target_height;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // ------------------------------------------------------------------
    // Parser mirror: configuration, frame state and latched target
    // ------------------------------------------------------------------
    logic [15:0]        gap_limit_ms;
    t_parse_phase       parse_phase;
    logic [7:0]         frame_cmd_q;
    logic [7:0]         frame_len_q;
    logic [7:0]         payload_idx;
    logic [7:0]         check_sum;
    logic [31:0]        last_stamp;
    logic [7:0]         payload_copy [ftpp_pkg::BUF_BYTES_DEF];
    ftpp_pkg::t_result  target_q;

    // Per-request results still owed by the block, oldest first
    ftpp_pkg::t_result  expected_results [$];

    // Stimulus state
    logic [31:0]  clock_ms;          // timestamp of the last byte offered
    logic [7:0]   body_bytes [$];    // payload for the next send_frame call
    int           bytes_sent;
    int           results_seen;
    int           mismatches;
    int           hold_off_cycles;   // nonzero: receiver holds off this many cycles
    bit           sender_steady;
    bit           receiver_steady;

    framed_target_packet_parser_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_done     (o_frame_done),
        .o_frame_cmd      (o_frame_cmd),
        .o_target_detected(o_target_detected),
        .o_target_x       (o_target_x),
        .o_target_y       (o_target_y),
        .o_target_width   (o_target_width),
        .o_target_height  (o_target_height),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin : run_limit
        #10_000_000;
        $display("framed_target_packet_parser_unit_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Mirror of the parser: advance the state by one byte and return the
    // result that byte must produce.
    // ------------------------------------------------------------------
    function automatic ftpp_pkg::t_result parse_rx_byte(input logic [7:0] rx,
                                                        input logic [31:0] stamp);
        ftpp_pkg::t_result res;
        logic              good_frame;
        logic [31:0]       elapsed;
        good_frame = 1'b0;
        elapsed    = stamp - last_stamp;
        // Drop a frame whose bytes came too far apart; the byte then starts a new hunt
        if (parse_phase != HUNT_SYNC_A && elapsed > 32'(gap_limit_ms)) begin
            parse_phase = HUNT_SYNC_A;
        end
        last_stamp = stamp;
        case (parse_phase)
            HUNT_SYNC_A: begin
                if (rx == ftpp_pkg::SYNC_A) begin
                    parse_phase = HUNT_SYNC_B;
                    check_sum   = rx;
                end
            end
            HUNT_SYNC_B: begin
                // A wrong second sync byte is consumed, not retried as a first one
                if (rx == ftpp_pkg::SYNC_B) begin
                    parse_phase = TAKE_CMD;
                    check_sum   = check_sum + rx;
                end else begin
                    parse_phase = HUNT_SYNC_A;
                end
            end
            TAKE_CMD: begin
                frame_cmd_q = rx;
                check_sum   = check_sum + rx;
                parse_phase = TAKE_LEN;
            end
            TAKE_LEN: begin
                frame_len_q = rx;
                if (int'(rx) > ftpp_pkg::BUF_BYTES_DEF) begin
                    parse_phase = HUNT_SYNC_A;
                end else begin
                    check_sum   = check_sum + rx;
                    payload_idx = '0;
                    parse_phase = (rx == 8'h00) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                if (int'(payload_idx) < ftpp_pkg::BUF_BYTES_DEF) begin
                    payload_copy[payload_idx] = rx;
                end
                payload_idx = payload_idx + 8'd1;
                check_sum   = check_sum + rx;
                if (payload_idx >= frame_len_q) begin
                    parse_phase = TAKE_CHECKSUM;
                end
            end
            TAKE_CHECKSUM: begin
                if (check_sum == rx) begin
                    if (frame_cmd_q == ftpp_pkg::TARGET_CMD &&
                        frame_len_q >= ftpp_pkg::TARGET_MIN_LEN) begin
                        target_q.target_detected = payload_copy[0];
                        target_q.target_x        = {payload_copy[1], payload_copy[2]};
                        target_q.target_y        = {payload_copy[3], payload_copy[4]};
                        target_q.target_width    = {payload_copy[5], payload_copy[6]};
                        target_q.target_height   = {payload_copy[7], payload_copy[8]};
                    end
                    good_frame = 1'b1;
                end
                parse_phase = HUNT_SYNC_A;
            end
            default: begin
                parse_phase = HUNT_SYNC_A;
            end
        endcase
        res            = target_q;
        res.frame_done = good_frame;
        res.frame_cmd  = frame_cmd_q;
        return res;
    endfunction

    // Mostly short idle gaps, now and then a long one
    function automatic int pick_idle();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return int'($urandom_range(1, 3));
        if (pick < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(30, 60));
    endfunction

    // Time step between two bytes of one frame that stays within the limit,
    // with the exact limit and one below it hit often
    function automatic logic [31:0] in_frame_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return $urandom_range(0, (gap_limit_ms < 16'd3) ? gap_limit_ms : 16'd3);
        if (pick < 80) return $urandom_range(0, gap_limit_ms);
        if (pick < 92) return 32'(gap_limit_ms);
        return (gap_limit_ms == 16'd0) ? 32'd0 : 32'(gap_limit_ms) - 32'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH result %0d %s: expected %0h, got %0h",
                     results_seen, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        ftpp_pkg::t_result want;
        ftpp_pkg::t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_frame_done, o_frame_cmd, o_target_detected, o_target_x, o_target_y,
                    o_target_width, o_target_height};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH result %0d arrived with no request pending",
                             results_seen);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.frame_done !== want.frame_done)
                    report_mismatch("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                if (got.frame_cmd !== want.frame_cmd)
                    report_mismatch("frame_cmd", 32'(want.frame_cmd), 32'(got.frame_cmd));
                if (got.target_detected !== want.target_detected)
                    report_mismatch("target_detected", 32'(want.target_detected),
                                    32'(got.target_detected));
                if (got.target_x !== want.target_x)
                    report_mismatch("target_x", 32'(want.target_x), 32'(got.target_x));
                if (got.target_y !== want.target_y)
                    report_mismatch("target_y", 32'(want.target_y), 32'(got.target_y));
                if (got.target_width !== want.target_width)
                    report_mismatch("target_width", 32'(want.target_width),
                                    32'(got.target_width));
                if (got.target_height !== want.target_height)
                    report_mismatch("target_height", 32'(want.target_height),
                                    32'(got.target_height));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, steady stretches, and a long hold-off
    // counted here on request of a test
    // ------------------------------------------------------------------
    initial begin : result_ready_driver
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready = 1'b0;
                repeat (hold_off_cycles - 1) @(negedge i_clk);
                hold_off_cycles = 0;
            end else if (receiver_steady || stall_left == 0) begin
                i_out_ready = 1'b1;
                if (!receiver_steady && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_idle();
                end
            end else begin
                i_out_ready = 1'b0;
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender: advance the timestamp by step, offer the byte after a
    // random gap, hold it until accepted, then record what it must produce
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] rx, input logic [31:0] step);
        int idle;
        idle     = sender_steady ? 0 : pick_idle();
        clock_ms = clock_ms + step;
        @(negedge i_clk);
        if (idle > 0) begin
            i_in_valid = 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = rx;
        i_now_ms   = clock_ms;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(parse_rx_byte(rx, clock_ms));
        bytes_sent++;
    endtask

    // Drop valid and hold until every request has its result
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Write gap_timeout over the register port, then read it back
    task automatic write_gap_timeout(input logic [15:0] limit_ms);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = GAP_TIMEOUT_ADDR;
        pwdata  = DATA_W'(limit_ms);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        gap_limit_ms = limit_ms;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(limit_ms)) begin
            report_mismatch("gap_timeout read-back", 32'(limit_ms), 32'(prdata));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Send sync, command, length, body_bytes and checksum, with one fault
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input t_frame_fault fault);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        int         stop_at;
        int         late_at;
        frame_bytes = {ftpp_pkg::SYNC_A, ftpp_pkg::SYNC_B, cmd, len};
        foreach (body_bytes[i]) frame_bytes.push_back(body_bytes[i]);
        sum = '0;
        foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
        if (fault == FRAME_BAD_SUM) begin
            sum = sum ^ 8'(1 << $urandom_range(0, 7));
        end
        frame_bytes.push_back(sum);
        stop_at = frame_bytes.size();
        late_at = -1;
        if (fault == FRAME_TRUNCATED) stop_at = int'($urandom_range(1, frame_bytes.size() - 1));
        if (fault == FRAME_LATE_BYTE) late_at = int'($urandom_range(1, frame_bytes.size() - 1));
        for (int i = 0; i < stop_at; i++) begin
            if (i == late_at) begin
                // Just past the limit: the frame must be dropped here
                send_byte(frame_bytes[i], 32'(gap_limit_ms) + 32'($urandom_range(1, 3)));
            end else begin
                send_byte(frame_bytes[i], in_frame_step());
            end
        end
    endtask

    // One random frame, mostly well formed, or a burst of line noise
    task automatic send_random_traffic();
        int unsigned  pick;
        int unsigned  len_pick;
        logic [7:0]   cmd;
        logic [7:0]   len;
        t_frame_fault fault;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            // Noise, sometimes after a long silence on the link
            if ($urandom_range(0, 2) == 0) clock_ms = $urandom();
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom()), in_frame_step());
            return;
        end
        cmd      = ($urandom_range(0, 1) == 1) ? ftpp_pkg::TARGET_CMD : 8'($urandom());
        len_pick = $urandom_range(0, 99);
        if (len_pick < 50) begin
            len = 8'($urandom_range(ftpp_pkg::TGT_BYTES, ftpp_pkg::TGT_BYTES + 3));
        end else if (len_pick < 75) begin
            len = 8'($urandom_range(0, ftpp_pkg::TGT_BYTES - 1));
        end else if (len_pick < 85) begin
            len = 8'(ftpp_pkg::BUF_BYTES_DEF);
        end else if (len_pick < 92) begin
            len = 8'($urandom_range(ftpp_pkg::TGT_BYTES + 4, ftpp_pkg::BUF_BYTES_DEF - 1));
        end else begin
            len = 8'($urandom_range(ftpp_pkg::BUF_BYTES_DEF + 1, 255));
        end
        body_bytes.delete();
        // An oversize length aborts the frame, so only a few stray bytes follow it
        repeat ((int'(len) > ftpp_pkg::BUF_BYTES_DEF) ? int'($urandom_range(0, 3))
                                                      : int'(len)) begin
            body_bytes.push_back(8'($urandom()));
        end
        if (pick < 65)      fault = FRAME_GOOD;
        else if (pick < 76) fault = FRAME_BAD_SUM;
        else if (pick < 85) fault = FRAME_LATE_BYTE;
        else                fault = FRAME_TRUNCATED;
        send_frame(cmd, len, fault);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header faults and the empty frame
    task automatic test_header_faults();
        // A repeated first sync byte ends the hunt; the 0xAA after it must not count
        send_byte(ftpp_pkg::SYNC_A, 32'd1);
        send_byte(ftpp_pkg::SYNC_A, 32'd1);
        send_byte(ftpp_pkg::SYNC_B, 32'd1);
        // A length past the buffer drops the frame right after the length byte
        send_byte(ftpp_pkg::SYNC_A, 32'd1);
        send_byte(ftpp_pkg::SYNC_B, 32'd1);
        send_byte(ftpp_pkg::TARGET_CMD, 32'd1);
        send_byte(8'(ftpp_pkg::BUF_BYTES_DEF + 1), 32'd1);
        // An empty payload goes straight to the checksum
        body_bytes.delete();
        send_frame(8'h07, 8'h00, FRAME_GOOD);
    endtask

    // Latch a target with extreme fields, starting the timestamp just below its wrap point
    task automatic test_target_extremes();
        clock_ms   = 32'hFFFF_FFFB;
        body_bytes = {8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame(ftpp_pkg::TARGET_CMD, ftpp_pkg::TARGET_MIN_LEN, FRAME_GOOD);
    endtask

    // Run random traffic under each gap limit, the extremes included
    task automatic test_gap_timeout_settings();
        logic [15:0] limits [5];
        int          start;
        limits[0] = 16'd0;
        limits[1] = 16'hFFFF;
        limits[2] = 16'd1;
        limits[3] = 16'($urandom());
        limits[4] = ftpp_pkg::GAP_TIMEOUT_RST;
        foreach (limits[k]) begin
            wait_until_drained();
            write_gap_timeout(limits[k]);
            start = bytes_sent;
            while (bytes_sent < start + 70) send_random_traffic();
        end
    endtask

    // Bulk random frames, in two halves with a new gap limit between them
    task automatic test_random_frames();
        while (bytes_sent < 560) send_random_traffic();
        wait_until_drained();
        write_gap_timeout(16'($urandom_range(2, 40)));
        while (bytes_sent < 750) send_random_traffic();
    endtask

    // Hold off results while bytes keep coming, so the input stalls; then
    // pause the sender until every result is in
    task automatic test_output_hold_off();
        int start;
        hold_off_cycles = 400;
        sender_steady   = 1'b1;
        start           = bytes_sent;
        while (bytes_sent < start + 40) send_random_traffic();
        sender_steady = 1'b0;
        wait_until_drained();
    endtask

    // Back-to-back requests with no stalls on either side
    task automatic test_steady_stream();
        int start;
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        start           = bytes_sent;
        while (bytes_sent < start + 60) send_random_traffic();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = '0;
        i_now_ms   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        gap_limit_ms = ftpp_pkg::GAP_TIMEOUT_RST;
        parse_phase  = HUNT_SYNC_A;
        frame_cmd_q  = '0;
        frame_len_q  = '0;
        payload_idx  = '0;
        check_sum    = '0;
        last_stamp   = '0;
        target_q     = '0;
        foreach (payload_copy[i]) payload_copy[i] = '0;

        clock_ms        = $urandom();
        bytes_sent      = 0;
        results_seen    = 0;
        mismatches      = 0;
        hold_off_cycles = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_faults();
        test_target_extremes();
        test_gap_timeout_settings();
        test_random_frames();
        test_output_hold_off();
        test_steady_stream();

        // Drain, then watch a few more cycles for stray results
        wait_until_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("framed_target_packet_parser_unit_test OK");
        end else begin
            $display("framed_target_packet_parser_unit_test NOT OK");
        end
        $finish;
    end

endmodule
